>>> sv/sfr_pkg.sv
package sfr_pkg;

    localparam int LEN_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam logic [LEN_W-1:0] REP_MAX_LEN = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN   = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic take_match;
        logic emit_rep;
        logic emit_shed;
        logic last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_match;
        logic need_shed;
        logic more_shed;
        logic rep_empty;
        logic rep_last;
        logic out_free;
    } t_sts;

endpackage

>>> sv/sfr_ctrl.sv
module sfr_ctrl import sfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_REP    = 4'b0100,
        S_SHED   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_match) begin
                    o_cmd.take_match = 1'b1;
                    n_state = i_sts.rep_empty ? S_IDLE : S_REP;
                end else if (i_sts.need_shed) begin
                    n_state = S_SHED;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_REP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_rep = 1'b1;
                    o_cmd.last     = i_sts.rep_last;
                    if (i_sts.rep_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SHED: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_shed = 1'b1;
                    o_cmd.last      = !i_sts.more_shed;
                    if (!i_sts.more_shed) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/sfr_dp.sv
module sfr_dp import sfr_pkg::*; #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  t_in_item             i_in,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_out_valid,
    output t_out_item            o_out,
    input  logic                 i_out_stall
);

    localparam int FW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    logic [63:0]      r_pat;
    logic [LEN_W-1:0] r_plen;
    logic [63:0]      r_rep;
    logic [LEN_W-1:0] r_rlen;

    logic [7:0]    r_win [MAX_PATTERN];
    logic [FW-1:0] r_fill;
    logic          r_end;
    logic [2:0]    r_k;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [LEN_W-1:0] plen_eff;
    logic [LEN_W-1:0] rlen_eff;
    logic [LEN_W-1:0] fill_ext;
    logic [FW-1:0]    n1;
    logic [IW-1:0]    app_idx;
    logic             win_ok;
    logic             sh_ok;
    logic             out_free;

    always_comb begin
        if (r_plen == '0) begin
            plen_eff = LEN_W'(1);
        end else if (r_plen > MAX_LEN) begin
            plen_eff = MAX_LEN;
        end else begin
            plen_eff = r_plen;
        end
        rlen_eff = (r_rlen > REP_MAX_LEN) ? REP_MAX_LEN : r_rlen;
    end

    assign fill_ext = LEN_W'(r_fill);
    assign n1       = r_fill - FW'(1);
    assign app_idx  = (r_fill > FW'(MAX_PATTERN - 1)) ? IW'(MAX_PATTERN - 1) : IW'(r_fill);

    // window prefix compare, and the same compare after dropping the front byte
    always_comb begin
        win_ok = 1'b1;
        sh_ok  = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (FW'(i) < r_fill && r_win[i] != r_pat[8*i +: 8]) begin
                win_ok = 1'b0;
            end
        end
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            if (FW'(i) < n1 && r_win[i+1] != r_pat[8*i +: 8]) begin
                sh_ok = 1'b0;
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts.is_match  = (fill_ext == plen_eff) && win_ok;
        o_sts.need_shed = (r_fill != '0) && (r_end || !((fill_ext < plen_eff) && win_ok));
        o_sts.more_shed = (n1 != '0) && (r_end || !((LEN_W'(n1) < plen_eff) && sh_ok));
        o_sts.rep_empty = (rlen_eff == '0);
        o_sts.rep_last  = (LEN_W'(r_k) + LEN_W'(1)) == rlen_eff;
        o_sts.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= LEN_W'(1);
            r_rep  <= '0;
            r_rlen <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PAT_BYTES: r_pat  <= i_cfg_data;
                CFG_PAT_LEN:   r_plen <= i_cfg_data[LEN_W-1:0];
                CFG_REP_BYTES: r_rep  <= i_cfg_data;
                CFG_REP_LEN:   r_rlen <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (IW'(i) == app_idx) begin
                    r_win[i] <= i_in.text_byte;
                end
            end
        end else if (i_cmd.emit_shed) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_end  <= 1'b0;
            r_k    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_fill <= FW'(app_idx) + FW'(1);
                r_end  <= i_in.text_end;
            end else if (i_cmd.take_match) begin
                r_fill <= '0;
                r_k    <= '0;
            end else if (i_cmd.emit_rep) begin
                r_k <= r_k + 3'd1;
            end else if (i_cmd.emit_shed) begin
                r_fill <= n1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_rep || i_cmd.emit_shed) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_rep || i_cmd.emit_shed) begin
            r_out.out_byte  <= i_cmd.emit_rep ? r_rep[{r_k, 3'b000} +: 8] : r_win[0];
            r_out.run_last  <= i_cmd.last;
            r_out.text_done <= i_cmd.last && r_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> sv/stream_find_replace.sv
// stream find and replace: text enters one byte per item and every non-overlapping
// occurrence of the pattern (1 to MAX_PATTERN bytes) is replaced by the replacement
// (0 to 8 bytes, zero deletes). bytes that may still start a match are held back in
// a window until they are resolved; the item marked text_end flushes the window.
// one input item is accepted, then checked against the window, and then releases its
// result bytes in turn; the single output register paces the result bytes and a stalled
// output holds the controller. run_last marks the last result of an item and text_done
// the last result of the text; an item that releases nothing gives no result. write
// configuration only while the block is idle.
module stream_find_replace import sfr_pkg::*; #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sfr_dp #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> sv/sfr_chk.sv
module sfr_chk import sfr_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // the window check takes the cycle after an accepted item
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted during window check");

    // no new item while a run of results is unfinished
    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.run_last |-> o_in_stall)
        else $error("input open in the middle of a run");

    // end of text only on the last result of a run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.text_done |-> o_out.run_last)
        else $error("text_done without run_last");

endmodule

bind stream_find_replace sfr_chk u_sfr_chk (.*);

>>> dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sfr_pkg::*;

    class rewrite_scoreboard;
        logic [63:0] pat_bytes;
        logic [3:0]  pat_len;
        logic [63:0] rep_bytes;
        logic [3:0]  rep_len;
        logic [7:0]  window [8];
        int unsigned fill;
        t_out_item   expected_q[$];
        int          errors;

        function new();
            pat_bytes = '0;
            pat_len   = 4'd1;
            rep_bytes = '0;
            rep_len   = '0;
            fill      = 0;
            errors    = 0;
            foreach (window[i]) window[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                CFG_PAT_BYTES: pat_bytes = data;
                CFG_PAT_LEN:   pat_len = data[3:0];
                CFG_REP_BYTES: rep_bytes = data;
                CFG_REP_LEN:   rep_len = data[3:0];
                default: ;
            endcase
        endfunction

        function bit is_prefix(int unsigned n);
            for (int unsigned i = 0; i < n; i++) begin
                if (window[i] != pat_bytes[8*i +: 8]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // rewrite one text byte and queue the bytes it releases
        function void note_text_item(t_in_item item);
            int unsigned plen;
            int unsigned rlen;
            int unsigned n;
            t_out_item   run[$];
            t_out_item   tail;
            plen = (pat_len == 0) ? 1 : ((pat_len > 8) ? 8 : pat_len);
            rlen = (rep_len > 8) ? 8 : rep_len;
            n = (fill > 7) ? 7 : fill;
            window[n] = item.text_byte;
            n++;
            if (n == plen && is_prefix(n)) begin
                for (int unsigned i = 0; i < rlen; i++) begin
                    run.push_back(t_out_item'{out_byte: rep_bytes[8*i +: 8],
                                              run_last: 1'b0, text_done: 1'b0});
                end
                n = 0;
            end else begin
                // shed leading bytes until the rest is a proper prefix again
                while (n > 0 && !(n < plen && is_prefix(n))) begin
                    run.push_back(t_out_item'{out_byte: window[0],
                                              run_last: 1'b0, text_done: 1'b0});
                    for (int unsigned i = 0; i + 1 < n; i++) window[i] = window[i+1];
                    n--;
                end
            end
            if (item.text_end) begin
                for (int unsigned i = 0; i < n; i++) begin
                    run.push_back(t_out_item'{out_byte: window[i],
                                              run_last: 1'b0, text_done: 1'b0});
                end
                n = 0;
            end
            fill = n;
            if (run.size() > 0) begin
                tail = run.pop_back();
                tail.run_last  = 1'b1;
                tail.text_done = item.text_end;
                run.push_back(tail);
            end
            foreach (run[i]) expected_q.push_back(run[i]);
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_out_item(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item, byte %02h", got.out_byte));
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h",
                                          got.out_byte, want.out_byte));
            if (got.run_last !== want.run_last)
                report_mismatch($sformatf("run_last %b, want %b",
                                          got.run_last, want.run_last));
            if (got.text_done !== want.text_done)
                report_mismatch($sformatf("text_done %b, want %b",
                                          got.text_done, want.text_done));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left = 0;
    logic        hold_req = 1'b0;
    logic        hold_taken = 1'b0;
    logic [63:0] gen_pat = '0;
    int unsigned gen_plen = 1;
    int unsigned gen_pos = 0;

    rewrite_scoreboard sb;

    stream_find_replace #(.MAX_PATTERN(8)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: a long hold-off overrides the random stalls
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            i_out_stall <= 1'b1;
            hold_left <= 199;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_out_item(o_out);
    end

    task automatic send_text(input logic [7:0] b, input logic e);
        int unsigned gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(4, 1) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= t_in_item'{text_byte: b, text_end: e};
        do @(posedge i_clk); while (o_in_stall);
        sb.note_text_item(t_in_item'{text_byte: b, text_end: e});
        @(negedge i_clk);
    endtask

    // items that release nothing may still be in flight when the queue empties
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic load_config(input logic [63:0] pb, input logic [3:0] pl,
                               input logic [63:0] rb, input logic [3:0] rl);
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        write_cfg(CFG_PAT_BYTES, pb);
        write_cfg(CFG_PAT_LEN, {junk[63:4], pl});
        write_cfg(CFG_REP_BYTES, rb);
        write_cfg(CFG_REP_LEN, {junk[59:0], rl});
        i_cfg_valid <= 1'b0;
        gen_pat  = pb;
        gen_plen = (pl == 0) ? 1 : ((pl > 8) ? 8 : pl);
        gen_pos  = 0;
    endtask

    initial begin
        logic [63:0] pb;
        logic [7:0]  sym_a;
        logic [7:0]  sym_b;
        logic [7:0]  b;
        logic [3:0]  pl;
        logic [3:0]  rl;
        logic        e;
        int unsigned r;
        logic [87:0] abc_text;
        sb = new();
        send_idle_pct = 23;
        recv_idle_pct = 86;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: single zero byte deleted, end item with nothing released
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b1);
        wait_drained();

        // match, shed on a broken prefix, flush of a partial prefix at the end
        load_config(64'h636261, 4'd3, 64'h5958, 4'd2);
        abc_text = 88'h6261006362616261636261;
        for (int i = 0; i < 11; i++) send_text(abc_text[8*i +: 8], i == 10);
        wait_drained();

        // zero pattern length counts as one, oversized replacement as eight
        load_config(64'hFF, 4'd0, '1, 4'd15);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b1);
        wait_drained();

        // oversized pattern length counts as eight; hold seven bytes pending
        load_config(64'h0807060504030201, 4'd15, 64'h0, 4'd0);
        for (int i = 1; i < 8; i++) send_text(8'(i), 1'b0);
        wait_drained();
        // pattern shrinks under a window longer than it
        load_config(64'h0201, 4'd2, 64'hA5, 4'd1);
        send_text(8'h08, 1'b1);

        for (int phase = 0; phase < 6; phase++) begin
            wait_drained();
            if (phase == 2) begin
                send_idle_pct = 86;
                recv_idle_pct = 23;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 0) pl = 4'd8;
            else if (phase == 1) pl = 4'd1;
            else if ($urandom_range(99) < 80) pl = 4'($urandom_range(8, 1));
            else pl = ($urandom_range(7) == 0) ? 4'd0 : 4'($urandom_range(15, 9));
            if (phase == 0) rl = 4'd8;
            else if (phase == 1) rl = 4'd0;
            else if ($urandom_range(99) < 80) rl = 4'($urandom_range(8, 0));
            else rl = 4'($urandom_range(15, 9));
            // two-symbol patterns give overlapping prefixes
            if ($urandom_range(1) == 1) begin
                sym_a = 8'($urandom());
                sym_b = 8'($urandom());
                for (int i = 0; i < 8; i++) pb[8*i +: 8] = $urandom_range(1) ? sym_a : sym_b;
            end else begin
                pb = {$urandom(), $urandom()};
            end
            load_config(pb, pl, {$urandom(), $urandom()}, rl);
            if (phase == 4) begin
                @(posedge i_clk);
                hold_req = 1'b1;
                @(negedge i_clk);
            end
            for (int k = 0; k < 24; k++) begin
                if (phase == 5 && k == 12) wait_drained();
                r = $urandom_range(99);
                if (r < 55) begin
                    b = gen_pat[8*(gen_pos % gen_plen) +: 8];
                    gen_pos++;
                end else if (r < 75) begin
                    b = gen_pat[7:0];
                    gen_pos = 1;
                end else begin
                    b = 8'($urandom_range(255));
                    gen_pos = 0;
                end
                e = ($urandom_range(99) < 8) || (k == 23 && phase % 2 == 1);
                send_text(b, e);
            end
        end
        wait_drained();

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
